@@ hw/rtl/box_blur_3x3_rgb_defines.svh @@
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb_defines
// Assertion macros of the box blur RTL.
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_DEFINES_SVH

// same-cycle implication, clocked by aclk, off while aresetn is low
`define BB3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked by aclk, off while aresetn is low
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bb3_pkg.sv @@
// ---------------------------------------------------------------------------
// bb3_pkg
// Types and constants of the 3x3 RGBA box blur.
// ---------------------------------------------------------------------------
package bb3_pkg;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } bb3_pix_t;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } bb3_reg_t;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_RAW_W  = 11;
    localparam int HEIGHT_RAW_W = 13;
    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 768;

    // nine 8-bit values
    localparam int SUM_W = 12;
    localparam int PROD_W = 24;
    // floor(x / 9) == (x * 3641) >> 15 for every x below 32768
    localparam logic [SUM_W-1:0] DIV9_MUL = 12'd3641;
    localparam int DIV9_SHIFT = 15;

endpackage

@@ hw/rtl/bb3_line_store.sv @@
// ---------------------------------------------------------------------------
// bb3_line_store
// Two line delays in synchronous memories. The near line is read
// and rewritten on each request; the far line takes the near line's old value
// when stage A advances (adv), with forwarding to a read of the same column.
// ---------------------------------------------------------------------------
module bb3_line_store
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
    input  bb3_pix_t                     wr_px,
    input  logic                         wr_pixel,
    input  logic                         adv,
    output bb3_pix_t                     top_px,
    output bb3_pix_t                     mid_px,
    output logic                         mid_valid
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [32:0]      near_mem [MAX_WIDTH];
    bb3_pix_t         far_mem  [MAX_WIDTH];
    logic [32:0]      near_q_reg;
    bb3_pix_t         far_q_reg;
    bb3_pix_t         fwd_px_reg;
    logic [COL_W-1:0] col_reg;
    logic             fwd_reg, fwd_next;
    logic             known_reg, known_next;
    logic [COL_W:0]   fill_reg, fill_next;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            near_q_reg       <= near_mem[rd_col];
            near_mem[rd_col] <= {wr_pixel, wr_px};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            far_q_reg <= far_mem[rd_col];
        end
        if (adv) begin
            far_mem[col_reg] <= mid_px;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            col_reg    <= rd_col;
            fwd_px_reg <= mid_px;
        end
    end

    always_comb begin
        fill_next  = fill_reg;
        fwd_next   = fwd_reg;
        known_next = known_reg;
        if (rd_en) begin
            fwd_next   = adv && (col_reg == rd_col);
            known_next = ({1'b0, rd_col} < fill_reg);
            if ({1'b0, rd_col} >= fill_reg) begin
                fill_next = {1'b0, rd_col} + (COL_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            fwd_reg   <= 1'b0;
            known_reg <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            fwd_reg   <= fwd_next;
            known_reg <= known_next;
        end
    end

    assign mid_px    = known_reg ? bb3_pix_t'(near_q_reg[31:0]) : '0;
    assign mid_valid = known_reg & near_q_reg[32];
    assign top_px    = fwd_reg ? fwd_px_reg : far_q_reg;

endmodule

@@ hw/rtl/box_blur_3x3_rgb.sv @@
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 mean filter on R, G, B of an RGBA raster stream; borders and alpha pass.
// Throughput: one request per cycle unless the output stalls; one read and one
// write port per line memory. A result waits for the request width+1 places later.
// Reset: synchronous, clears control, counters and window; line memories are not
// cleared, a fill pointer marks written columns instead (no clearing pass).
// ---------------------------------------------------------------------------
`include "box_blur_3x3_rgb_defines.svh"

module box_blur_3x3_rgb
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  bb3_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_red,
    input  logic [7:0]            s_in_green,
    input  logic [7:0]            s_in_blue,
    input  logic [7:0]            s_in_alpha,
    input  logic                  s_is_flush,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_red,
    output logic [7:0]            m_out_green,
    output logic [7:0]            m_out_blue,
    output logic [7:0]            m_out_alpha,
    output logic                  m_frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WW    = COL_W + 1;
    localparam int HW    = ROW_W + 1;
    localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

    // configuration
    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [31:0]   raw;

    assign cfg_ready = 1'b1;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        raw         = '0;
        if (cfg_valid) begin
            case (cfg_index)
                REG_WIDTH: begin
                    raw = 32'(cfg_data[WIDTH_RAW_W-1:0]);
                    if (raw == 32'd0) begin
                        width_next = WW'(1);
                    end else if (raw > 32'(MAX_WIDTH)) begin
                        width_next = WW'(MAX_WIDTH);
                    end else begin
                        width_next = WW'(raw);
                    end
                end
                REG_HEIGHT: begin
                    raw = 32'(cfg_data[HEIGHT_RAW_W-1:0]);
                    if (raw == 32'd0) begin
                        height_next = HW'(1);
                    end else if (raw > 32'(MAX_HEIGHT)) begin
                        height_next = HW'(MAX_HEIGHT);
                    end else begin
                        height_next = HW'(raw);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // handshake chain
    logic s_accept, a_adv, cap, x_adv, o_ready, x_ready, w_free;
    logic a_valid_reg, w_pend_reg, wv2_reg, x_valid_reg, m_valid_reg;

    assign o_ready  = !m_valid_reg || m_ready;
    assign x_adv    = x_valid_reg && o_ready;
    assign x_ready  = !x_valid_reg || x_adv;
    assign cap      = w_pend_reg && x_ready;
    assign w_free   = !w_pend_reg || x_ready;
    assign a_adv    = a_valid_reg && w_free;
    assign s_ready  = !a_valid_reg || a_adv;
    assign s_accept = s_valid && s_ready;

    // input column
    logic [COL_W-1:0] in_col_reg, in_col_next, col;
    bb3_pix_t         in_px;

    assign col   = ({1'b0, in_col_reg} >= width_reg) ? '0 : in_col_reg;
    assign in_px = s_is_flush ? '0 : {s_in_alpha, s_in_blue, s_in_green, s_in_red};

    always_comb begin
        in_col_next = in_col_reg;
        if (s_accept) begin
            if ({1'b0, col} + WW'(1) >= width_reg) begin
                in_col_next = '0;
            end else begin
                in_col_next = col + COL_W'(1);
            end
        end
    end

    // line memories
    bb3_pix_t top_px, mid_px;
    logic     mid_valid;

    bb3_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lines (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_col    (col),
        .wr_px     (in_px),
        .wr_pixel  (!s_is_flush),
        .adv       (a_adv),
        .top_px    (top_px),
        .mid_px    (mid_px),
        .mid_valid (mid_valid)
    );

    // stage A payload
    bb3_pix_t a_px_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_px_reg <= in_px;
        end
    end

    // window
    bb3_pix_t win_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (a_adv) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2] <= top_px;
            win_reg[5] <= mid_px;
            win_reg[8] <= a_px_reg;
        end
    end

    // output position
    logic [COL_W-1:0] out_col_reg, out_col_next, oc;
    logic [ROW_W-1:0] out_row_reg, out_row_next, orow;
    logic             last_col, last_row, interior;

    assign oc       = ({1'b0, out_col_reg} >= width_reg) ? '0 : out_col_reg;
    assign orow     = ({1'b0, out_row_reg} >= height_reg) ? '0 : out_row_reg;
    assign last_col = ({1'b0, oc} + WW'(1) >= width_reg);
    assign last_row = ({1'b0, orow} + HW'(1) >= height_reg);
    assign interior = (orow != '0) && !last_row && (oc != '0) && !last_col;

    always_comb begin
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cap) begin
            if (last_col) begin
                out_col_next = '0;
                out_row_next = last_row ? '0 : orow + ROW_W'(1);
            end else begin
                out_col_next = oc + COL_W'(1);
                out_row_next = orow;
            end
        end
    end

    // neighborhood sums
    logic [SUM_W-1:0] sum [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = '0;
            for (int i = 0; i < 9; i++) begin
                sum[k] = sum[k] + SUM_W'(win_reg[i][8*k +: 8]);
            end
        end
    end

    logic [SUM_W-1:0] x_sum_reg [3];
    bb3_pix_t         x_center_reg;
    logic             x_interior_reg, x_end_reg;

    always_ff @(posedge aclk) begin
        if (cap) begin
            for (int k = 0; k < 3; k++) begin
                x_sum_reg[k] <= sum[k];
            end
            x_center_reg   <= win_reg[4];
            x_interior_reg <= interior;
            x_end_reg      <= last_col && last_row;
        end
    end

    // divide by nine and output register
    logic [PROD_W-1:0] prod [3];
    logic [7:0]        res  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = PROD_W'(x_sum_reg[k]) * PROD_W'(DIV9_MUL);
            res[k]  = x_interior_reg ? prod[k][DIV9_SHIFT +: 8] : x_center_reg[8*k +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (x_adv) begin
            m_out_red   <= res[0];
            m_out_green <= res[1];
            m_out_blue  <= res[2];
            m_out_alpha <= x_center_reg.alpha;
            m_frame_end <= x_end_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WW'(RST_W);
            height_reg  <= HW'(RST_H);
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            a_valid_reg <= 1'b0;
            wv2_reg     <= 1'b0;
            w_pend_reg  <= 1'b0;
            x_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (s_accept) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                wv2_reg    <= mid_valid;
                w_pend_reg <= wv2_reg;
            end else if (cap) begin
                w_pend_reg <= 1'b0;
            end
            if (cap) begin
                x_valid_reg <= 1'b1;
            end else if (x_adv) begin
                x_valid_reg <= 1'b0;
            end
            if (x_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `BB3_ASSERT_NEXT(a_hold_chk, a_valid_reg && !a_adv, a_valid_reg && $stable(a_px_reg), "stage A request changed while stalled")
    `BB3_ASSERT_NEXT(pend_hold_chk, w_pend_reg && !cap, w_pend_reg, "pending window result dropped")
    `BB3_ASSERT_NEXT(end_wrap_chk, cap && last_col && last_row, out_col_reg == '0 && out_row_reg == '0, "position did not wrap at frame end")
    `BB3_ASSERT_NOW(interior_end_chk, x_valid_reg && x_interior_reg, !x_end_reg, "interior pixel flagged as frame end")

endmodule
